### sv/cvdp_pkg.sv
// ----------------------------------------------------------------------------
// cvdp_pkg
// Types and constants shared by the cell vote, descramble and packer block.
// ----------------------------------------------------------------------------
package cvdp_pkg;

    localparam int LUMA_SUM_W  = 15;
    localparam int PIX_CNT_W   = 7;
    localparam int AREA_W      = 4;
    localparam int CELL_IDX_W  = 6;
    localparam int THRESH_W    = 12;
    localparam int BYTE_W      = 8;
    localparam int FRAC_W      = 4;
    localparam int SCALED_W    = LUMA_SUM_W + FRAC_W;
    localparam int HASH_W      = 9;
    localparam int BITCNT_W    = 3;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd2048;
    localparam logic [BITCNT_W-1:0] BITCNT_LAST  = 3'd7;

    // Only the low nine bits of the hash reach bit 8, so the whole hash is
    // folded into one constant term plus two constant products.
    localparam logic [31:0] HASH_SEED   = 32'd12345;
    localparam logic [31:0] HASH_MUL    = 32'd1103515245;
    localparam logic [31:0] HASH_BASE   = HASH_SEED * HASH_MUL;
    localparam logic [31:0] HASH_MUL_SQ = HASH_MUL * HASH_MUL;
    localparam logic [31:0] HASH_CONST  = HASH_BASE * HASH_MUL_SQ;

    localparam logic [HASH_W-1:0] HASH_K0 = HASH_CONST[HASH_W-1:0];
    localparam logic [HASH_W-1:0] HASH_M1 = HASH_MUL[HASH_W-1:0];
    localparam logic [HASH_W-1:0] HASH_M2 = HASH_MUL_SQ[HASH_W-1:0];

    typedef struct packed {
        logic push;
        logic dbit;
    } bitq_wr_t;

    typedef struct packed {
        logic empty;
        logic dbit;
    } bitq_rd_t;

endpackage

### sv/cvdp_front.sv
// ----------------------------------------------------------------------------
// cvdp_front
// Accepts cells, holds the threshold, and classifies each cell into one
// descrambled bit.
// ----------------------------------------------------------------------------
module cvdp_front
    import cvdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [THRESH_W-1:0]   cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [LUMA_SUM_W-1:0] luma_sum,
    input  logic [PIX_CNT_W-1:0]  pixel_count,
    input  logic [AREA_W-1:0]     area,
    input  logic [CELL_IDX_W-1:0] cell_row,
    input  logic [CELL_IDX_W-1:0] cell_col,
    input  logic                  q_full,
    output bitq_wr_t              q_wr
);

    logic [THRESH_W-1:0] thresh_reg;
    logic                valid_reg;
    logic                valid_next;
    logic [SCALED_W-1:0] scaled_reg;
    logic [SCALED_W-1:0] scaled_next;
    logic [SCALED_W-1:0] prod_reg;
    logic [SCALED_W-1:0] prod_next;
    logic                hbit_reg;
    logic                hbit_next;
    logic [HASH_W-1:0]   hash;
    logic                accept;
    logic                move;

    assign move   = valid_reg && !q_full;
    assign full   = valid_reg && q_full;
    assign accept = push && !full;

    always_comb
    begin
        hash = HASH_K0 + HASH_W'(area) * HASH_M2 + HASH_W'(cell_row) * HASH_M1
             + HASH_W'(cell_col);
        hbit_next   = hash[HASH_W-1];
        scaled_next = {luma_sum, {FRAC_W{1'b0}}};
        prod_next   = SCALED_W'(thresh_reg) * SCALED_W'(pixel_count);
        valid_next  = accept || (valid_reg && !move);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                thresh_reg <= cfg_data;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scaled_reg <= scaled_next;
            prod_reg   <= prod_next;
            hbit_reg   <= hbit_next;
        end
    end

    assign q_wr.push = move;
    assign q_wr.dbit = (scaled_reg < prod_reg) ^ hbit_reg;

endmodule

### sv/cvdp_bitq.sv
// ----------------------------------------------------------------------------
// cvdp_bitq
// Short queue of classified bits between the front and the packer.
// ----------------------------------------------------------------------------
module cvdp_bitq
    import cvdp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  bitq_wr_t q_wr,
    output logic     q_full,
    input  logic     q_pop,
    output bitq_rd_t q_rd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DEPTH-1:0] data_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign q_full     = (count_reg == CNT_FULL);
    assign q_rd.empty = (count_reg == '0);
    assign q_rd.dbit  = data_reg[rd_ptr_reg];
    assign do_push    = q_wr.push && !q_full;
    assign do_pop     = q_pop && !q_rd.empty;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= q_wr.dbit;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_FULL)
        else $error("bit queue count exceeds depth");
    assert property (@(posedge clk) disable iff (!rst_n) !(q_wr.push && q_full))
        else $error("bit queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && q_rd.empty))
        else $error("bit queue read while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("bit queue count missed a write");

endmodule

### sv/cvdp_back.sv
// ----------------------------------------------------------------------------
// cvdp_back
// Packs queued bits MSB first and holds each finished byte for transfer.
// ----------------------------------------------------------------------------
module cvdp_back
    import cvdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  bitq_rd_t          q_rd,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] data_byte
);

    logic [BYTE_W-2:0]   shift_reg;
    logic [BYTE_W-2:0]   shift_next;
    logic [BITCNT_W-1:0] cnt_reg;
    logic [BITCNT_W-1:0] cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [BYTE_W-1:0]   data_byte_reg;
    logic [BYTE_W-1:0]   data_byte_next;
    logic                out_free;
    logic                take;
    logic                emit;

    assign out_free = !out_valid_reg || pop;
    assign take     = !q_rd.empty && ((cnt_reg != BITCNT_LAST) || out_free);
    assign emit     = take && (cnt_reg == BITCNT_LAST);
    assign q_pop    = take;

    always_comb
    begin
        shift_next     = shift_reg;
        cnt_next       = cnt_reg;
        data_byte_next = data_byte_reg;
        out_valid_next = out_valid_reg && !pop;
        if (emit)
        begin
            data_byte_next = {shift_reg, q_rd.dbit};
            out_valid_next = 1'b1;
            shift_next     = '0;
            cnt_next       = '0;
        end
        else if (take)
        begin
            shift_next = {shift_reg[BYTE_W-3:0], q_rd.dbit};
            cnt_next   = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            shift_reg     <= shift_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_byte_reg <= data_byte_next;
    end

    assign empty     = !out_valid_reg;
    assign data_byte = data_byte_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (cnt_reg == '0) && (shift_reg == '0) && out_valid_reg)
        else $error("packer did not restart after a byte");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |-> !emit)
        else $error("packer overwrote a waiting byte");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> out_valid_reg && $stable(data_byte_reg))
        else $error("waiting byte changed before its transfer");

endmodule

### sv/cell_vote_descramble_packer_core.sv
// ----------------------------------------------------------------------------
// cell_vote_descramble_packer_core
// Cell vote, descramble and byte packer for visual code data cells.
// ----------------------------------------------------------------------------
// Each cell pushed in is voted dark when 16 * luma_sum is below
// dark_threshold * pixel_count, the vote is XORed with bit 8 of the cell's
// position hash, and the bits are packed MSB first; every eighth cell yields
// one byte. A cell is accepted every cycle as long as the bit queue and the
// output byte register drain; a cell is registered in the front stage and
// its bit in the bit queue before the packer takes it, and a byte is visible
// on the cycle after its eighth bit is packed. The only stall source is a
// byte left waiting on the output. Partial bytes are kept until reset.
// ----------------------------------------------------------------------------
module cell_vote_descramble_packer_core
    import cvdp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [THRESH_W-1:0]   cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [LUMA_SUM_W-1:0] luma_sum,
    input  logic [PIX_CNT_W-1:0]  pixel_count,
    input  logic [AREA_W-1:0]     area,
    input  logic [CELL_IDX_W-1:0] cell_row,
    input  logic [CELL_IDX_W-1:0] cell_col,
    output logic                  empty,
    input  logic                  pop,
    output logic [BYTE_W-1:0]     data_byte
);

    bitq_wr_t q_wr;
    bitq_rd_t q_rd;
    logic     q_full;
    logic     q_pop;

    cvdp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .luma_sum    (luma_sum),
        .pixel_count (pixel_count),
        .area        (area),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .q_full      (q_full),
        .q_wr        (q_wr)
    );

    cvdp_bitq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_bitq (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_pop  (q_pop),
        .q_rd   (q_rd)
    );

    cvdp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd      (q_rd),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .data_byte (data_byte)
    );

endmodule
